/* design/kcs_pkg.sv */
// Package for the k-combination successor block.
// Holds field widths, register indexes, reset values and the status struct.
// No dependencies; used by kcs_successor and k_combination_successor.
`default_nettype none

package kcs_pkg;

	// Fixed widths of the configuration registers and of the result fields.
	localparam int SET_W    = 7;
	localparam int CHOOSE_W = 4;
	localparam int ELEM_W   = 6;
	localparam int OUT_SLOTS = 8;
	localparam int OUT_DATA_W = OUT_SLOTS * ELEM_W;
	localparam int IN_DATA_W  = 8;

	// Width used for limits n-k+i and for the n against MAX_SET check.
	localparam int LIM_W = 9;

	localparam logic [SET_W-1:0]    SET_SIZE_RESET     = 7'd8;
	localparam logic [CHOOSE_W-1:0] CHOOSE_COUNT_RESET = 4'd4;

	typedef enum logic [0:0] {
		REG_SET_SIZE     = 1'b0,
		REG_CHOOSE_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic is_last;
		logic bad_config;
		logic started;
	} kcs_status_t;

endpackage

`default_nettype wire

/* design/kcs_successor.sv */
// Combinational successor logic: picks the rightmost element that can still
// grow, bumps it and refills the tail, or loads the first combination; a bad
// configuration gives all zeros. Depends on kcs_pkg.
`default_nettype none

module kcs_successor #(
	parameter int MAX_CHOOSE = 8,
	parameter int MAX_SET    = 64,
	localparam int EW = (MAX_SET > 2) ? $clog2(MAX_SET) : 1,
	localparam int PW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1
) (
	input  wire logic [EW-1:0]                       cur [MAX_CHOOSE],
	input  wire logic                                started,
	input  wire logic                                restart,
	input  wire logic [kcs_pkg::SET_W-1:0]           set_size,
	input  wire logic [kcs_pkg::CHOOSE_W-1:0]        choose_count,
	output logic      [EW-1:0]                       nxt [MAX_CHOOSE],
	output logic      [kcs_pkg::ELEM_W-1:0]          elem [kcs_pkg::OUT_SLOTS],
	output kcs_pkg::kcs_status_t                     status
);

	logic [kcs_pkg::LIM_W-1:0] limit [MAX_CHOOSE];
	logic [MAX_CHOOSE-1:0]     qual;
	logic                      bad;
	logic                      found;
	logic [PW-1:0]             pos;
	logic [kcs_pkg::LIM_W-1:0] base;
	logic                      last;

	always_comb begin
		bad = (choose_count == '0)
			|| (choose_count > kcs_pkg::CHOOSE_W'(MAX_CHOOSE))
			|| (kcs_pkg::LIM_W'(set_size) > kcs_pkg::LIM_W'(MAX_SET))
			|| (kcs_pkg::LIM_W'(choose_count) > kcs_pkg::LIM_W'(set_size));

		// Element i may still grow while it is below n-k+i.
		for (int i = 0; i < MAX_CHOOSE; i++) begin
			limit[i] = kcs_pkg::LIM_W'(set_size) - kcs_pkg::LIM_W'(choose_count)
				+ kcs_pkg::LIM_W'(i);
			qual[i] = (kcs_pkg::CHOOSE_W'(i) < choose_count)
				&& (kcs_pkg::LIM_W'(cur[i]) < limit[i]);
		end

		// The highest qualifying position wins.
		found = 1'b0;
		pos   = '0;
		for (int i = 0; i < MAX_CHOOSE; i++) begin
			if (qual[i]) begin
				found = 1'b1;
				pos   = PW'(i);
			end
		end
		base = kcs_pkg::LIM_W'(cur[pos]) + kcs_pkg::LIM_W'(1);

		for (int i = 0; i < MAX_CHOOSE; i++) begin
			if (bad) begin
				nxt[i] = '0;
			end else if (restart || !started || !found) begin
				nxt[i] = (kcs_pkg::CHOOSE_W'(i) < choose_count) ? EW'(i) : '0;
			end else if ((kcs_pkg::LIM_W'(i) >= kcs_pkg::LIM_W'(pos))
					&& (kcs_pkg::CHOOSE_W'(i) < choose_count)) begin
				nxt[i] = EW'(base + kcs_pkg::LIM_W'(i) - kcs_pkg::LIM_W'(pos));
			end else begin
				nxt[i] = cur[i];
			end
		end

		last = !bad;
		for (int i = 0; i < MAX_CHOOSE; i++) begin
			if ((kcs_pkg::CHOOSE_W'(i) < choose_count)
					&& (kcs_pkg::LIM_W'(nxt[i]) != limit[i]))
				last = 1'b0;
		end

		for (int s = 0; s < kcs_pkg::OUT_SLOTS; s++) begin
			elem[s] = '0;
			if ((s < MAX_CHOOSE) && !bad && (kcs_pkg::CHOOSE_W'(s) < choose_count))
				elem[s] = kcs_pkg::ELEM_W'(kcs_pkg::LIM_W'(nxt[s % MAX_CHOOSE]));
		end

		status.is_last    = last;
		status.bad_config = bad;
		status.started    = !bad;
	end

endmodule

`default_nettype wire

/* design/k_combination_successor.sv */
// Top level of the k-combination successor: input register, state and
// configuration registers, and the result register around kcs_successor.
// Depends on kcs_pkg and kcs_successor.
//
//  Channel  Direction  Payload
//  s_*      in         tdata[0] restart
//  m_*      out        tdata elem_0..elem_7 (6 bits each), tlast is_last,
//                      tuser bad_config
//  cfg_*    in         cfg_addr 0 set_size, 1 choose_count; cfg_wdata value
//
// One combination per clock while m_tready is high; the successor step
// from the input register to the result register is one pass of compare
// and priority pick over MAX_CHOOSE elements; an accepted item sits in
// each in turn, the result register driving m_tvalid. Reset loads n = 8,
// k = 4 and clears the current combination. A stalled result register
// holds the next item in the input register; s_tready drops only when both are full.
`default_nettype none

module k_combination_successor #(
	parameter int MAX_CHOOSE = 8,
	parameter int MAX_SET    = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [kcs_pkg::IN_DATA_W-1:0]     s_tdata,   // [0] restart, rest zero
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [kcs_pkg::OUT_DATA_W-1:0]    m_tdata,   // elem_0 .. elem_7
	output logic                                   m_tlast,   // is_last
	output logic      [0:0]                        m_tuser,   // [0] bad_config
	input  wire logic                              cfg_we,
	input  wire logic [0:0]                        cfg_addr,
	input  wire logic [kcs_pkg::SET_W-1:0]         cfg_wdata
);

	localparam int EW = (MAX_SET > 2) ? $clog2(MAX_SET) : 1;

	logic                            valid_s1;
	logic                            restart_s1;
	logic [EW-1:0]                   cur_q [MAX_CHOOSE];
	logic                            started_q;
	logic [kcs_pkg::SET_W-1:0]       set_size_q;
	logic [kcs_pkg::CHOOSE_W-1:0]    choose_count_q;
	logic                            out_valid_q;
	logic [kcs_pkg::OUT_DATA_W-1:0]  out_data_q;
	logic                            out_last_q;
	logic                            out_bad_q;

	logic [EW-1:0]                   nxt [MAX_CHOOSE];
	logic [kcs_pkg::ELEM_W-1:0]      elem [kcs_pkg::OUT_SLOTS];
	kcs_pkg::kcs_status_t            status;
	logic                            advance;
	logic [kcs_pkg::OUT_DATA_W-1:0]  packed_elems;

	kcs_successor #(
		.MAX_CHOOSE (MAX_CHOOSE),
		.MAX_SET    (MAX_SET)
	) u_succ (
		.cur          (cur_q),
		.started      (started_q),
		.restart      (restart_s1),
		.set_size     (set_size_q),
		.choose_count (choose_count_q),
		.nxt          (nxt),
		.elem         (elem),
		.status       (status)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		for (int s = 0; s < kcs_pkg::OUT_SLOTS; s++)
			packed_elems[s*kcs_pkg::ELEM_W +: kcs_pkg::ELEM_W] = elem[s];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			restart_s1 <= s_tdata[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHOOSE; i++)
				cur_q[i] <= '0;
			started_q <= 1'b0;
		end else if (advance) begin
			cur_q     <= nxt;
			started_q <= status.started;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q     <= kcs_pkg::SET_SIZE_RESET;
			choose_count_q <= kcs_pkg::CHOOSE_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (kcs_pkg::reg_idx_t'(cfg_addr))
				kcs_pkg::REG_SET_SIZE:     set_size_q     <= cfg_wdata;
				kcs_pkg::REG_CHOOSE_COUNT: choose_count_q <= cfg_wdata[kcs_pkg::CHOOSE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= packed_elems;
			out_last_q <= status.is_last;
			out_bad_q  <= status.bad_config;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tlast    = out_last_q;
	assign m_tuser[0] = out_bad_q;

`ifndef NO_ASSERTIONS
	// A bad configuration clears the sequence so the next item starts afresh.
	a_bad_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status.bad_config |=> !started_q)
		else $error("started flag survived a bad configuration");

	// A flagged result carries no elements and is never the last combination.
	a_bad_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tlast)
		else $error("bad_config result with non-zero payload");

	// An empty input register always takes a new transaction.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with an empty input register");

	// Every step through the successor leaves a result to be taken.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("computed result was lost");
`endif

endmodule

`default_nettype wire

/* dv/tb_k_combination_successor.sv */
// Self-checking testbench for k_combination_successor: directed and random
// restart/advance streams against a built-in lexicographic successor predictor.
// Depends on kcs_pkg and the k_combination_successor RTL.
`timescale 1ns / 100ps

module tb_k_combination_successor;

	localparam int MAX_CHOOSE   = 8;
	localparam int MAX_SET      = 64;
	localparam int LATENCY      = 2;
	localparam int ITEM_TARGET  = 1450;
	localparam int TAIL_ITEMS   = 120;

	typedef struct packed {
		logic [kcs_pkg::OUT_SLOTS-1:0][kcs_pkg::ELEM_W-1:0] elem;
		logic                                               is_last;
		logic                                               bad_config;
	} comb_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [kcs_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [kcs_pkg::OUT_DATA_W-1:0] m_tdata;    // elem_0 .. elem_7, 6 bits each
	logic                           m_tlast;    // is_last
	logic [0:0]                     m_tuser;    // [0] bad_config
	logic                           cfg_we;
	logic [0:0]                     cfg_addr;
	logic [kcs_pkg::SET_W-1:0]      cfg_wdata;

	// Predictor state: the stored combination and the register copies.
	int unsigned  cur_comb [MAX_CHOOSE];
	bit           comb_started;
	int unsigned  pred_set_size;
	int unsigned  pred_choose_count;

	comb_result_t expected_combs [$];
	int unsigned  accepted_items;
	int unsigned  checked_results;
	int unsigned  mismatches;
	bit           src_idle_en;
	bit           sink_stall_en;
	int unsigned  sink_hold_cycles;

	k_combination_successor #(
		.MAX_CHOOSE(MAX_CHOOSE),
		.MAX_SET(MAX_SET)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void load_first_combination();
		for (int i = 0; i < MAX_CHOOSE; i++)
			cur_comb[i] = (i < pred_choose_count) ? i : 0;
	endfunction

	// Advances the predicted state by one transaction and returns the result it yields.
	function automatic comb_result_t next_combination(bit restart);
		comb_result_t res;
		int           n;
		int           k;
		int           pos;
		bit           found;
		int unsigned  base;
		res = '0;
		n = pred_set_size;
		k = pred_choose_count;
		if (k == 0 || k > MAX_CHOOSE || n > MAX_SET || k > n) begin
			for (int i = 0; i < MAX_CHOOSE; i++)
				cur_comb[i] = 0;
			comb_started = 1'b0;
			res.bad_config = 1'b1;
			return res;
		end
		if (restart || !comb_started) begin
			load_first_combination();
			comb_started = 1'b1;
		end else begin
			found = 1'b0;
			pos = 0;
			for (int j = k - 1; j >= 0; j--) begin
				if (!found && cur_comb[j] < n - k + j) begin
					pos = j;
					found = 1'b1;
				end
			end
			if (found) begin
				base = cur_comb[pos] + 1;
				for (int i = pos; i < k; i++)
					cur_comb[i] = base + (i - pos);
			end else begin
				load_first_combination();
			end
		end
		res.is_last = 1'b1;
		for (int i = 0; i < k; i++) begin
			if (cur_comb[i] != n - k + i)
				res.is_last = 1'b0;
			res.elem[i] = cur_comb[i][kcs_pkg::ELEM_W-1:0];
		end
		return res;
	endfunction

	task automatic flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ERROR: %s", $realtime, msg);
	endtask

	// Result checker: every output transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		comb_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_combs.size() == 0) begin
				flag_error("result arrived with no combination outstanding");
			end else begin
				exp_res = expected_combs.pop_front();
				for (int i = 0; i < kcs_pkg::OUT_SLOTS; i++) begin
					if (m_tdata[i*kcs_pkg::ELEM_W +: kcs_pkg::ELEM_W] !== exp_res.elem[i])
						flag_error($sformatf("result %0d elem_%0d: expected %0d, got %0d",
							checked_results, i, exp_res.elem[i],
							m_tdata[i*kcs_pkg::ELEM_W +: kcs_pkg::ELEM_W]));
				end
				if (m_tlast !== exp_res.is_last)
					flag_error($sformatf("result %0d is_last: expected %0b, got %0b",
						checked_results, exp_res.is_last, m_tlast));
				if (m_tuser[0] !== exp_res.bad_config)
					flag_error($sformatf("result %0d bad_config: expected %0b, got %0b",
						checked_results, exp_res.bad_config, m_tuser[0]));
			end
			checked_results++;
		end
	end

	// Receiver: random stall bursts, plus a long hold-off when one is requested.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_cycles > 0) begin
				m_tready = 1'b0;
				sink_hold_cycles--;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (sink_stall_en && $urandom_range(0, 4) == 0) begin
				m_tready = 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance with
	// s_tvalid still high, so back-to-back items keep the valid asserted.
	task automatic send_item(bit restart);
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {{(kcs_pkg::IN_DATA_W-1){1'b0}}, restart};
		do
			@(posedge clk);
		while (!s_tready);
		expected_combs.push_back(next_combination(restart));
		accepted_items++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (expected_combs.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(kcs_pkg::reg_idx_t idx, int unsigned value);
		wait_idle();
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = value[kcs_pkg::SET_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == kcs_pkg::REG_SET_SIZE)
			pred_set_size = value & 7'h7F;
		else
			pred_choose_count = value & 4'hF;
	endtask

	task automatic set_config(int unsigned n, int unsigned k);
		write_reg(kcs_pkg::REG_SET_SIZE, n);
		write_reg(kcs_pkg::REG_CHOOSE_COUNT, k);
	endtask

	// Reset values n = 8, k = 4; the first item gives the first combination even
	// without a restart.
	task automatic test_reset_defaults();
		send_item(1'b0);
		send_item(1'b0);
		send_item(1'b1);
	endtask

	task automatic test_set_extremes();
		set_config(64, 8);
		send_item(1'b1);
		send_item(1'b0);
		set_config(1, 1);
		send_item(1'b0);
		send_item(1'b0);
		set_config(8, 8);
		send_item(1'b1);
	endtask

	// Each unusable setting must clear the state, so the next good item restarts.
	task automatic test_bad_config();
		set_config(6, 2);
		send_item(1'b1);
		write_reg(kcs_pkg::REG_CHOOSE_COUNT, 0);
		send_item(1'b0);
		write_reg(kcs_pkg::REG_CHOOSE_COUNT, 9);
		send_item(1'b0);
		write_reg(kcs_pkg::REG_CHOOSE_COUNT, 15);
		send_item(1'b1);
		set_config(65, 4);
		send_item(1'b0);
		write_reg(kcs_pkg::REG_SET_SIZE, 127);
		send_item(1'b0);
		set_config(0, 1);
		send_item(1'b0);
		set_config(3, 4);
		send_item(1'b0);
		set_config(6, 2);
		send_item(1'b0);
	endtask

	// Register changes without a restart: the successor runs on the stored values,
	// and wraps when no element can be raised.
	task automatic test_midsequence_config();
		set_config(10, 3);
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b0);
		write_reg(kcs_pkg::REG_CHOOSE_COUNT, 5);
		send_item(1'b0);
		set_config(4, 3);
		send_item(1'b0);
		write_reg(kcs_pkg::REG_SET_SIZE, 3);
		send_item(1'b0);
		send_item(1'b0);
	endtask

	// Walks every value of a single element, reaching the top bit and the wrap.
	task automatic test_full_range_walk();
		set_config(64, 1);
		send_item(1'b1);
		repeat (66) send_item(1'b0);
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		src_idle_en = 1'b0;
		sink_hold_cycles = 48;
		set_config(7, 3);
		send_item(1'b1);
		repeat (23) send_item(1'b0);
		src_idle_en = 1'b1;
	endtask

	task automatic test_random_sweeps();
		int unsigned choice;
		int unsigned n;
		int unsigned k;
		int unsigned run_len;
		while (accepted_items < ITEM_TARGET - TAIL_ITEMS) begin
			choice = $urandom_range(0, 99);
			if (choice < 8) begin
				case ($urandom_range(0, 3))
					0: set_config($urandom_range(1, 64), 0);
					1: set_config($urandom_range(9, 64), $urandom_range(9, 15));
					2: set_config($urandom_range(65, 127), $urandom_range(1, 8));
					default: begin
						n = $urandom_range(0, 7);
						set_config(n, $urandom_range(n + 1, 8));
					end
				endcase
				run_len = $urandom_range(1, 3);
			end else if (choice < 22) begin
				// Change one register only, carrying the stored combination over.
				n = $urandom_range(1, 12);
				if ($urandom_range(0, 1))
					write_reg(kcs_pkg::REG_SET_SIZE, n);
				else
					write_reg(kcs_pkg::REG_CHOOSE_COUNT, $urandom_range(1, 8));
				run_len = $urandom_range(5, 30);
			end else begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
					: $urandom_range(1, 12);
				k = $urandom_range(1, (n < MAX_CHOOSE) ? n : MAX_CHOOSE);
				set_config(n, k);
				run_len = $urandom_range(10, 50);
			end
			src_idle_en = ($urandom_range(0, 3) != 0);
			sink_stall_en = ($urandom_range(0, 3) != 0);
			repeat (run_len) send_item($urandom_range(0, 15) == 0);
		end
	endtask

	task automatic test_no_idle_tail();
		wait_idle();
		src_idle_en = 1'b0;
		sink_stall_en = 1'b0;
		set_config(9, 4);
		send_item(1'b1);
		while (accepted_items < ITEM_TARGET)
			send_item($urandom_range(0, 31) == 0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = kcs_pkg::REG_SET_SIZE;
		cfg_wdata = '0;
		src_idle_en = 1'b1;
		sink_stall_en = 1'b1;
		sink_hold_cycles = 0;
		accepted_items = 0;
		checked_results = 0;
		mismatches = 0;
		pred_set_size = kcs_pkg::SET_SIZE_RESET;
		pred_choose_count = kcs_pkg::CHOOSE_COUNT_RESET;
		comb_started = 1'b0;
		for (int i = 0; i < MAX_CHOOSE; i++)
			cur_comb[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_set_extremes();
		test_bad_config();
		test_midsequence_config();
		test_full_range_walk();
		test_output_backpressure();
		test_random_sweeps();
		test_no_idle_tail();

		wait_idle();
		repeat (LATENCY + 8) @(negedge clk);
		if (mismatches == 0 && expected_combs.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Far beyond the slowest legal run of this stimulus.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
design/kcs_pkg.sv
design/kcs_successor.sv
design/k_combination_successor.sv
dv/tb_k_combination_successor.sv
